@@ hw/rtl/vsfc_pkg.sv @@
`default_nettype none

package vsfc_pkg;

    // frame geometry and packet layout
    localparam int ROWS         = 60;
    localparam int COLS         = 80;
    localparam int PACKET_BYTES = 164;
    localparam int PIXEL_FIRST  = 4;
    localparam int FRAME_WORDS  = ROWS * COLS;
    localparam int ADDR_W       = $clog2(FRAME_WORDS);

    localparam logic [7:0]        POS_PIX_FIRST = 8'(PIXEL_FIRST);
    localparam logic [7:0]        POS_PIX_END   = 8'(PIXEL_FIRST + 2 * COLS);
    localparam logic [7:0]        POS_LAST      = 8'(PACKET_BYTES - 1);
    localparam logic [8:0]        POS_COUNT     = 9'(PACKET_BYTES);
    localparam logic [7:0]        LINE_LIMIT    = 8'(ROWS);
    localparam logic [7:0]        LINE_FINAL    = 8'(ROWS - 1);
    localparam logic [3:0]        ID_DISCARD    = 4'hF;
    localparam logic [ADDR_W-1:0] ADDR_LAST     = ADDR_W'(FRAME_WORDS - 1);
    localparam logic [ADDR_W-1:0] COLS_A        = ADDR_W'(COLS);

    localparam logic RESULT_PIXEL = 1'b0;
    localparam logic RESULT_FRAME = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [5:0]  pixel_row;
        logic [6:0]  pixel_col;
        logic [15:0] pixel_value;
        logic [15:0] frame_min;
        logic [15:0] frame_max;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FRAME
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic addr_step;
        logic accept;
        logic scan_init;
        logic scan_rd;
        logic push_frame;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic addr_last;
        logic frame_due;
        logic q_full;
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/vsfc_ctrl.sv @@
`default_nettype none

module vsfc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire vsfc_pkg::t_status i_status,
    output vsfc_pkg::t_cmd        o_cmd
);
    import vsfc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    assign in_fire = i_valid && o_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.addr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire && i_status.frame_due) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.addr_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_FRAME;
            end
            ST_FRAME: begin
                if (!i_status.q_full) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr  = 1'b1;
                o_cmd.addr_step = 1'b1;
            end
            ST_IDLE: begin
                o_ready         = !i_status.q_full;
                o_cmd.accept    = i_valid && !i_status.q_full;
                o_cmd.scan_init = i_valid && !i_status.q_full && i_status.frame_due;
            end
            ST_SCAN: begin
                o_cmd.scan_rd   = 1'b1;
                o_cmd.addr_step = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_FRAME: begin
                o_cmd.push_frame = !i_status.q_full;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/vsfc_datapath.sv @@
`default_nettype none

module vsfc_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vsfc_pkg::t_item   i_item,
    input  wire vsfc_pkg::t_cmd    i_cmd,
    output vsfc_pkg::t_status      o_status,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output vsfc_pkg::t_result      o_result
);
    import vsfc_pkg::*;

    // packet parser state
    logic [7:0]  r_pos;
    logic        r_discard;
    logic [7:0]  r_line;
    logic [7:0]  r_hold;
    logic [7:0]  n_pos;
    logic        n_discard;
    logic [7:0]  n_line;
    logic [7:0]  n_hold;

    // frame store and sweep counter
    logic [15:0]       mem [FRAME_WORDS];
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic [15:0]       r_rd_data;
    logic              r_rd_valid;
    logic [15:0]       r_min;
    logic [15:0]       r_max;

    // result queue, two entries
    t_result     r_q [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;

    logic [7:0]        pos;
    logic [8:0]        pos_inc;
    logic [7:0]        off;
    logic              in_pix;
    logic              pix_done;
    logic              pix_out;
    logic [6:0]        col;
    logic [15:0]       value;
    logic              frame_due;
    logic [ADDR_W-1:0] pix_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              push;
    logic              pop;
    t_result           push_data;

    // byte decode
    always_comb begin
        pos      = i_item.packet_start ? 8'd0 : r_pos;
        pos_inc  = {1'b0, pos} + 9'd1;
        off      = pos - POS_PIX_FIRST;
        in_pix   = (pos >= POS_PIX_FIRST) && (pos < POS_PIX_END);
        pix_done = in_pix && off[0];
        col      = off[7:1];
        value    = {r_hold, i_item.data_byte};
        pix_out  = pix_done && !r_discard && (r_line < LINE_LIMIT);

        n_discard = r_discard;
        n_line    = r_line;
        n_hold    = r_hold;
        if (pos == 8'd0) begin
            n_discard = (i_item.data_byte[3:0] == ID_DISCARD);
        end else if (pos == 8'd1) begin
            if (!r_discard) n_line = i_item.data_byte;
        end else if (in_pix && !off[0]) begin
            n_hold = i_item.data_byte;
        end
        n_pos = (pos_inc >= POS_COUNT) ? 8'd0 : pos_inc[7:0];

        frame_due = (pos == POS_LAST) && !n_discard && (n_line == LINE_FINAL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_discard <= 1'b0;
            r_line    <= '0;
            r_hold    <= '0;
        end else if (i_cmd.accept) begin
            r_pos     <= n_pos;
            r_discard <= n_discard;
            r_line    <= n_line;
            r_hold    <= n_hold;
        end
    end

    // sweep counter for clearing and scanning, wraps after the last word
    assign n_addr = (r_addr == ADDR_LAST) ? '0 : r_addr + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.addr_step) begin
            r_addr <= n_addr;
        end
    end

    // store write: clearing pass or pixel
    assign pix_addr = ADDR_W'(r_line) * COLS_A + ADDR_W'(col);
    assign wr_en    = i_cmd.clear_wr || (i_cmd.accept && pix_out);
    assign wr_addr  = i_cmd.clear_wr ? r_addr : pix_addr;
    assign wr_data  = i_cmd.clear_wr ? 16'd0 : value;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_cmd.scan_rd) r_rd_data <= mem[r_addr];
    end

    // running min and max over the read stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_min      <= 16'hFFFF;
            r_max      <= 16'h0000;
        end else begin
            r_rd_valid <= i_cmd.scan_rd;
            if (i_cmd.scan_init) begin
                r_min <= 16'hFFFF;
                r_max <= 16'h0000;
            end else if (r_rd_valid) begin
                if (r_rd_data < r_min) r_min <= r_rd_data;
                if (r_rd_data > r_max) r_max <= r_rd_data;
            end
        end
    end

    // result queue
    always_comb begin
        push_data = '0;
        if (i_cmd.push_frame) begin
            push_data.result_kind = RESULT_FRAME;
            push_data.frame_min   = r_min;
            push_data.frame_max   = r_max;
            push_data.last        = 1'b1;
        end else begin
            push_data.result_kind = RESULT_PIXEL;
            push_data.pixel_row   = r_line[5:0];
            push_data.pixel_col   = col;
            push_data.pixel_value = value;
            push_data.last        = !frame_due;
        end
    end

    assign push     = i_cmd.push_frame || (i_cmd.accept && pix_out);
    assign o_valid  = (r_cnt != 2'd0);
    assign pop      = o_valid && i_ready;
    assign o_result = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wptr] <= push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= !r_wptr;
            if (pop) r_rptr <= !r_rptr;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // status to controller
    assign o_status.addr_last = (r_addr == ADDR_LAST);
    assign o_status.frame_due = frame_due;
    assign o_status.q_full    = (r_cnt == 2'd2);

endmodule

`default_nettype wire

@@ hw/rtl/video_spi_frame_capture_top.sv @@
// pixel result: written into the result queue with its byte transfer, and presented in the next cycle
// when no earlier result waits; throughput: one byte per cycle while the two-entry result queue has room
// frame result: follows a scan of the frame store after the final byte of line 59
// (one store read per cycle over 4800 words); no byte is taken during that scan
// reset: synchronous active low; a clearing pass over all 4800 words of the frame store
// follows, with no byte taken until it ends
`default_nettype none

module video_spi_frame_capture_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire vsfc_pkg::t_item   i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output vsfc_pkg::t_result      o_result
);
    import vsfc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencing
    vsfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // parser, frame store, scan and result queue
    vsfc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
